// ----- design/gser_pkg.sv -----
// ----------------------------------------------------------------------------
// gser_pkg
// Shared types and constants for the smoothing filter: register map and
// configuration port sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gser_pkg;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int TAP_FIELD_BITS = 16;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_HALF_WIDTH = 3'd0;
  localparam reg_idx_t REG_COEF_PAIR0 = 3'd1;
  localparam reg_idx_t REG_COEF_PAIR1 = 3'd2;
  localparam reg_idx_t REG_COEF_PAIR2 = 3'd3;
  localparam reg_idx_t REG_COEF_PAIR3 = 3'd4;

  localparam logic [2:0] HALF_WIDTH_RESET = 3'd3;
  localparam logic [31:0] COEF_PAIR0_RESET = 32'hFFFF_FFFF;

endpackage

// ----- design/gaussian_smoother_edge_renorm.sv -----
// ----------------------------------------------------------------------------
// gaussian_smoother_edge_renorm
// Symmetric FIR smoother with edge renormalization, one shared
// multiply-accumulate and a shift-subtract divider under a small sequencer.
//
// Usage:
//   Samples of a record enter on the s_* stream; s_tlast marks the last one.
//   Smoothed items leave on the m_* stream, lagging the input by half_width
//   items; the last input of a record flushes all owed outputs and the
//   final one carries m_tlast. The user must set taps and half_width over
//   APB only while the block is idle; the block does not enforce this.
//   Per output: a check state, a multiply and an accumulate state per tap
//   used (up to 2*half_width+1), a divider setup state, a divider producing
//   SAMPLE_BITS+1 quotient bits in turn (skipped on a zero tap sum) and an
//   output load state. An input item takes the idle and check states plus
//   the work for each output it releases. s_tready is high only while the
//   sequencer is idle. Results sit in an output register; a new input item
//   is accepted while it waits. When the receiver stalls, the sequencer
//   holds its next result until the register is free.
//   Reset (rst, synchronous) clears the record counters and the sequencer,
//   sets half_width to 3, coef_pair_0 to all ones and the other taps to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_smoother_edge_renorm
  import gser_pkg::*;
#(
  parameter int MAX_HALF    = 7,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: sample_in
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
  input  logic                                 s_tlast,
  // m_tdata: smoothed
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
  output logic                                 m_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [APB_ADDR_BITS-1:0]             paddr,
  input  logic [APB_DATA_BITS-1:0]             pwdata,
  output logic [APB_DATA_BITS-1:0]             prdata,
  output logic                                 pready
);

  localparam int TDW    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int WIN    = 2 * MAX_HALF + 1;
  localparam int JW     = $clog2(WIN);
  localparam int XW     = JW + 4;
  localparam int SW     = $clog2(WIN + 1);
  localparam int PW     = $clog2(MAX_HALF + 2);
  localparam int TAPW   = (COEF_BITS < TAP_FIELD_BITS) ? COEF_BITS : TAP_FIELD_BITS;
  localparam int PRW    = SAMPLE_BITS + TAPW + 1;
  localparam int ACCW   = PRW + JW;
  localparam int DENW   = TAPW + JW;
  localparam int QB     = SAMPLE_BITS + 1;
  localparam int QCW    = $clog2(QB);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DIVS  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                     state;
  logic [2:0]                     half_width;
  logic [31:0]                    coef0, coef1, coef2, coef3;
  logic signed [SAMPLE_BITS-1:0]  window [WIN];
  logic [SW-1:0]                  seen;
  logic [PW-1:0]                  pending;
  logic                           end_r;
  logic [JW-1:0]                  j;
  logic [JW-1:0]                  hi;
  logic [JW-1:0]                  age;
  logic signed [PRW-1:0]          prod;
  logic signed [ACCW-1:0]         acc;
  logic [DENW-1:0]                den;
  logic signed [SAMPLE_BITS-1:0]  center;
  logic                           neg;
  logic [ACCW-1:0]                rem;
  logic [ACCW-1:0]                dsh;
  logic [QB-1:0]                  quo;
  logic [QCW-1:0]                 qcnt;
  logic                           den_zero;

  logic [2:0]                     m_cur;
  logic [2:0]                     floor_cnt;
  logic [XW-1:0]                  a_x, m_x, lo_x, hi_x, seen_m1_x;
  logic [JW-1:0]                  tap_ofs_full;
  logic [2:0]                     tap_ofs;
  logic [31:0]                    coef_word;
  logic [TAPW-1:0]                tap_cur;
  logic [ACCW-1:0]                mag;
  logic [ACCW-1:0]                num;
  logic                           ge;
  logic signed [SAMPLE_BITS-1:0]  result;
  logic                           out_free;
  logic                           last_out;
  reg_idx_t                       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_HALF_WIDTH: prdata = {29'd0, half_width};
      REG_COEF_PAIR0: prdata = coef0;
      REG_COEF_PAIR1: prdata = coef1;
      REG_COEF_PAIR2: prdata = coef2;
      REG_COEF_PAIR3: prdata = coef3;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_WIDTH_RESET;
      coef0      <= COEF_PAIR0_RESET;
      coef1      <= '0;
      coef2      <= '0;
      coef3      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_HALF_WIDTH: half_width <= pwdata[2:0];
        REG_COEF_PAIR0: coef0 <= pwdata;
        REG_COEF_PAIR1: coef1 <= pwdata;
        REG_COEF_PAIR2: coef2 <= pwdata;
        REG_COEF_PAIR3: coef3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(half_width) > MAX_HALF) begin
      m_cur = 3'(MAX_HALF);
    end else begin
      m_cur = half_width;
    end
    floor_cnt    = end_r ? 3'd0 : m_cur;
    a_x          = XW'(pending) - XW'(1);
    m_x          = XW'(m_cur);
    lo_x         = (a_x > m_x) ? (a_x - m_x) : '0;
    seen_m1_x    = XW'(seen) - XW'(1);
    hi_x         = ((a_x + m_x) > seen_m1_x) ? seen_m1_x : (a_x + m_x);
    tap_ofs_full = (j > age) ? (j - age) : (age - j);
    tap_ofs      = tap_ofs_full[2:0];
  end

  always_comb begin
    unique case (tap_ofs[2:1])
      2'd0: coef_word = coef0;
      2'd1: coef_word = coef1;
      2'd2: coef_word = coef2;
      2'd3: coef_word = coef3;
    endcase
    tap_cur = tap_ofs[0] ? coef_word[TAP_FIELD_BITS +: TAPW] : coef_word[0 +: TAPW];
  end

  always_comb begin
    mag = acc[ACCW-1] ? (~acc + ACCW'(1)) : acc;
    num = mag + ACCW'(den >> 1);
    ge  = rem >= dsh;
  end

  always_comb begin
    if (den_zero) begin
      result = center;
    end else if (!neg) begin
      if (quo >= QB'(1) << (SAMPLE_BITS - 1)) begin
        result = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end else begin
        result = quo[SAMPLE_BITS-1:0];
      end
    end else begin
      if (quo > QB'(1) << (SAMPLE_BITS - 1)) begin
        result = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
        result = SAMPLE_BITS'(~quo + QB'(1));
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign last_out = end_r && (pending == PW'(1));
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      window[0] <= s_tdata[SAMPLE_BITS-1:0];
      for (int i = 1; i < WIN; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seen     <= '0;
      pending  <= '0;
      end_r    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            end_r <= s_tlast;
            if (int'(seen) < WIN) begin
              seen <= seen + SW'(1);
            end
            if (int'(pending) < MAX_HALF + 1) begin
              pending <= pending + PW'(1);
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (XW'(pending) > XW'(floor_cnt)) begin
            state <= ST_MUL;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MUL:  state <= ST_ACC;
        ST_ACC:  state <= (j == hi) ? ST_DIVS : ST_MUL;
        ST_DIVS: state <= (den == '0) ? ST_OUT : ST_DIV;
        ST_DIV:  state <= (qcnt == '0) ? ST_OUT : ST_DIV;
        ST_OUT: begin
          if (out_free) begin
            pending  <= pending - PW'(1);
            if (last_out) begin
              seen <= '0;
            end
            state <= ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_CHECK: begin
        age <= a_x[JW-1:0];
        j   <= lo_x[JW-1:0];
        hi  <= hi_x[JW-1:0];
        acc <= '0;
        den <= '0;
      end
      ST_MUL: begin
        prod <= PRW'(window[j]) * $signed({1'b0, tap_cur});
        den  <= den + DENW'(tap_cur);
        if (j == age) begin
          center <= window[j];
        end
      end
      ST_ACC: begin
        acc <= acc + ACCW'(prod);
        j   <= j + JW'(1);
      end
      ST_DIVS: begin
        neg      <= acc[ACCW-1];
        den_zero <= (den == '0);
        rem      <= num;
        dsh      <= ACCW'(den) << (QB - 1);
        qcnt     <= QCW'(QB - 1);
        quo      <= '0;
      end
      ST_DIV: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo  <= {quo[QB-2:0], ge};
        dsh  <= dsh >> 1;
        qcnt <= qcnt - QCW'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= TDW'({{(TDW - SAMPLE_BITS){1'b0}}, result});
          m_tlast <= last_out;
        end
      end
      default: ;
    endcase
  end

  a_pending_le_seen: assert property (@(posedge clk) disable iff (rst)
    SW'(pending) <= seen)
    else $error("owed outputs exceed samples held");

  a_record_closes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free && last_out) |=> (seen == '0 && pending == '0))
    else $error("record counters not cleared after final output");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dsh != '0 || qcnt == '0) && !den_zero)
    else $error("divider running on a zero tap sum");

endmodule
